// ===== rtl/core/tsae_pkg.sv =====
// Shared types, codes and defaults of the tile/sprite animation engine.
package tsae_pkg;

  localparam int TILE_ENTRIES_DEF = 256;
  localparam int SPRITE_SLOTS_DEF = 256;

  localparam int KIND_W  = 3;
  localparam int IDX_W   = 8;
  localparam int FRAME_W = 8;
  localparam int TIME_W  = 16;
  localparam int TIU_W   = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_TILE   = 3'd0,
    KIND_ADD_SPRITE  = 3'd1,
    KIND_DEL_SPRITE  = 3'd2,
    KIND_TICK        = 3'd3,
    KIND_READ_TILE   = 3'd4,
    KIND_READ_SPRITE = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_DIV,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_TT_RD,
    ST_TT_WR,
    ST_ST_RD,
    ST_ST_TRD,
    ST_ST_WR,
    ST_RD_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frames;
    logic [TIME_W-1:0]  period;
    logic               wraps;
    logic               stepping;
    logic [TIME_W-1:0]  phase;
    logic [FRAME_W-1:0] frame_now;
  } tile_word_t;

  typedef struct packed {
    logic               enabled;
    logic [IDX_W-1:0]   tile;
    logic               stepping;
    logic [TIME_W-1:0]  phase;
    logic [FRAME_W-1:0] frame_now;
  } slot_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]  phase;
    logic [FRAME_W-1:0] frame;
  } anim_pos_t;

  // One animation step: phase counts to the period, then the frame moves on.
  function automatic anim_pos_t advance(input anim_pos_t cur,
                                        input logic [TIME_W-1:0] period,
                                        input logic [FRAME_W-1:0] count,
                                        input logic wraps);
    anim_pos_t nxt;
    nxt = cur;
    if (cur.phase == period) begin
      nxt.phase = '0;
      nxt.frame = cur.frame + FRAME_W'(1);
      if (nxt.frame == count) begin
        nxt.frame = wraps ? '0 : nxt.frame - FRAME_W'(1);
      end
    end else begin
      nxt.phase = cur.phase + TIME_W'(1);
    end
    return nxt;
  endfunction

endpackage

// ===== rtl/core/tsae_req_if.sv =====
// Request channel: one operation item.
interface tsae_req_if;
  logic                         valid;
  logic                         ready;
  logic [tsae_pkg::KIND_W-1:0]  kind;
  logic [tsae_pkg::IDX_W-1:0]   index;
  logic [tsae_pkg::FRAME_W-1:0] frame_count;
  logic [tsae_pkg::TIME_W-1:0]  anim_time;
  logic                         loop_flag;

  modport source (output valid, kind, index, frame_count, anim_time, loop_flag,
                  input ready);
  modport sink (input valid, kind, index, frame_count, anim_time, loop_flag,
                output ready);
endinterface

// ===== rtl/core/tsae_rsp_if.sv =====
// Response channel: one result item per request.
interface tsae_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [tsae_pkg::IDX_W-1:0]   slot;
  logic [tsae_pkg::FRAME_W-1:0] frame;

  modport source (output valid, status, slot, frame, input ready);
  modport sink (input valid, status, slot, frame, output ready);
endinterface

// ===== rtl/core/tsae_cfg_if.sv =====
// Configuration write channel for tiles_in_use.
interface tsae_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tsae_pkg::TIU_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/tsae_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tsae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tsae_div.sv =====
// Iterative restoring divider: animation time by frame count, one bit a cycle.
module tsae_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsae_pkg::TIME_W-1:0]  dividend_i,
  input  logic [tsae_pkg::FRAME_W-1:0] divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [tsae_pkg::TIME_W-1:0]  quotient_o
);

  localparam int CW = $clog2(tsae_pkg::TIME_W);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [tsae_pkg::FRAME_W-1:0] rem_q, rem_d;
  logic [tsae_pkg::FRAME_W-1:0] dvs_q, dvs_d;
  logic [tsae_pkg::TIME_W-1:0]  quo_q, quo_d;
  logic [tsae_pkg::FRAME_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[tsae_pkg::TIME_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = tsae_pkg::FRAME_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[tsae_pkg::TIME_W-2:0], 1'b1};
      end else begin
        rem_d = tsae_pkg::FRAME_W'(trial);
        quo_d = {quo_q[tsae_pkg::TIME_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(tsae_pkg::TIME_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/tile_sprite_animation_engine.sv =====
// Top level: sequencer over the tile and sprite RAMs and the period divider.
// One item is taken at a time; ready is high only while the sequencer idles.
// Per item: load tile runs the 16-step divider, skipped with a frame count of
// zero; add sprite probes slots from the cursor (up to SPRITE_SLOTS); tick does
// one read-modify-write per entry over min(tiles_in_use, TILE_ENTRIES) tiles
// and then all SPRITE_SLOTS slots, through the single read port of each RAM.
// After reset a clearing pass over max(TILE_ENTRIES, SPRITE_SLOTS) addresses
// zeroes both RAMs before the first item is taken; configuration writes are
// taken at any time. The result sits in an output register, so the next item
// may enter while it waits.
module tile_sprite_animation_engine #(
  parameter int TILE_ENTRIES = tsae_pkg::TILE_ENTRIES_DEF,
  parameter int SPRITE_SLOTS = tsae_pkg::SPRITE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsae_req_if.sink   req_i,
  tsae_rsp_if.source rsp_o,
  tsae_cfg_if.sink   cfg_i
);

  localparam int TAW  = $clog2(TILE_ENTRIES);
  localparam int SAW  = $clog2(SPRITE_SLOTS);
  localparam int MAXD = (TILE_ENTRIES > SPRITE_SLOTS) ? TILE_ENTRIES : SPRITE_SLOTS;
  localparam int PW   = $clog2(MAXD) + 1;
  localparam int TWW  = $bits(tsae_pkg::tile_word_t);
  localparam int SWW  = $bits(tsae_pkg::slot_word_t);

  tsae_pkg::state_e state_q, state_d;

  logic [tsae_pkg::TIU_W-1:0]   tiu_q;
  logic [tsae_pkg::KIND_W-1:0]  kind_q;
  logic [tsae_pkg::IDX_W-1:0]   idx_q;
  logic [tsae_pkg::FRAME_W-1:0] cnt_q;
  logic                         loop_q;
  logic [PW-1:0]                ptr_q, ptr_d;
  logic [SAW-1:0]               cursor_q, cursor_d;
  tsae_pkg::slot_word_t         sw_q, sw_d;
  logic                         w_status_q, w_status_d;
  logic [tsae_pkg::IDX_W-1:0]   w_slot_q, w_slot_d;
  logic [tsae_pkg::FRAME_W-1:0] w_frame_q, w_frame_d;
  logic                         rsp_valid_q, rsp_valid_d;
  logic                         rsp_status_q;
  logic [tsae_pkg::IDX_W-1:0]   rsp_slot_q;
  logic [tsae_pkg::FRAME_W-1:0] rsp_frame_q;
  logic                         rsp_load;

  logic                         t_we, s_we;
  logic [TAW-1:0]               t_waddr, t_raddr;
  logic [SAW-1:0]               s_waddr, s_raddr;
  tsae_pkg::tile_word_t         t_wdata, t_rdata;
  tsae_pkg::slot_word_t         s_wdata, s_rdata;
  logic [TWW-1:0]               t_rbits;
  logic [SWW-1:0]               s_rbits;

  logic                         div_start, div_busy, div_done;
  logic [tsae_pkg::TIME_W-1:0]  div_quo;

  logic                         req_acc;
  logic                         tile_ok, slot_ok, stile_ok;
  logic [SAW-1:0]               cursor_nxt;
  tsae_pkg::anim_pos_t          pos_nxt;

  assign req_acc = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == tsae_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign t_rdata = tsae_pkg::tile_word_t'(t_rbits);
  assign s_rdata = tsae_pkg::slot_word_t'(s_rbits);

  assign tile_ok  = (int'(idx_q) < TILE_ENTRIES);
  assign slot_ok  = (int'(idx_q) < SPRITE_SLOTS);
  assign stile_ok = (int'(sw_q.tile) < TILE_ENTRIES);
  assign cursor_nxt = (int'(cursor_q) == SPRITE_SLOTS - 1) ? '0 : cursor_q + SAW'(1);

  tsae_ram #(.WIDTH(TWW), .DEPTH(TILE_ENTRIES)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rbits)
  );

  tsae_ram #(.WIDTH(SWW), .DEPTH(SPRITE_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rbits)
  );

  tsae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.anim_time),
    .divisor_i  (req_i.frame_count),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    cursor_d   = cursor_q;
    sw_d       = sw_q;
    w_status_d = w_status_q;
    w_slot_d   = w_slot_q;
    w_frame_d  = w_frame_q;
    rsp_load   = 1'b0;
    div_start  = 1'b0;
    t_we       = 1'b0;
    t_waddr    = TAW'(idx_q);
    t_wdata    = '0;
    t_raddr    = TAW'(idx_q);
    s_we       = 1'b0;
    s_waddr    = SAW'(idx_q);
    s_wdata    = '0;
    s_raddr    = SAW'(idx_q);
    pos_nxt    = '0;

    unique case (state_q)
      tsae_pkg::ST_CLEAR: begin
        t_waddr = ptr_q[TAW-1:0];
        s_waddr = ptr_q[SAW-1:0];
        t_we    = (int'(ptr_q) < TILE_ENTRIES);
        s_we    = (int'(ptr_q) < SPRITE_SLOTS);
        if (int'(ptr_q) == MAXD - 1) begin
          ptr_d   = '0;
          state_d = tsae_pkg::ST_IDLE;
        end else begin
          ptr_d = ptr_q + PW'(1);
        end
      end

      tsae_pkg::ST_IDLE: begin
        // look up the incoming index so its entries are ready in the next cycle
        t_raddr = TAW'(req_i.index);
        s_raddr = SAW'(req_i.index);
        if (req_acc) begin
          w_status_d = 1'b0;
          w_slot_d   = '0;
          w_frame_d  = '0;
          ptr_d      = '0;
          unique case (req_i.kind)
            tsae_pkg::KIND_LOAD_TILE: begin
              div_start = (req_i.frame_count != '0);
              state_d   = tsae_pkg::ST_LOAD_DIV;
            end
            tsae_pkg::KIND_ADD_SPRITE:  state_d = tsae_pkg::ST_ADD_RD;
            tsae_pkg::KIND_DEL_SPRITE:  state_d = tsae_pkg::ST_DEL_RD;
            tsae_pkg::KIND_TICK:        state_d = tsae_pkg::ST_TT_RD;
            tsae_pkg::KIND_READ_TILE:   state_d = tsae_pkg::ST_RD_WAIT;
            tsae_pkg::KIND_READ_SPRITE: state_d = tsae_pkg::ST_RD_WAIT;
            default:                    state_d = tsae_pkg::ST_FIN;
          endcase
        end
      end

      tsae_pkg::ST_LOAD_DIV: begin
        if (cnt_q == '0 || div_done) begin
          t_wdata.frames    = cnt_q;
          t_wdata.period    = (cnt_q == '0) ? '0 : div_quo;
          t_wdata.wraps     = loop_q;
          t_wdata.stepping  = (cnt_q > tsae_pkg::FRAME_W'(1));
          t_we              = tile_ok;
          state_d           = tsae_pkg::ST_FIN;
        end
      end

      tsae_pkg::ST_ADD_RD: begin
        s_raddr = cursor_q;
        state_d = tsae_pkg::ST_ADD_CHK;
      end

      tsae_pkg::ST_ADD_CHK: begin
        // tile read of idx_q stays valid while the probe runs
        if (!s_rdata.enabled) begin
          s_waddr          = cursor_q;
          s_wdata.enabled  = 1'b1;
          s_wdata.tile     = idx_q;
          s_wdata.stepping = tile_ok && (t_rdata.frames > tsae_pkg::FRAME_W'(1));
          s_we             = 1'b1;
          w_slot_d         = tsae_pkg::IDX_W'(cursor_q);
          state_d          = tsae_pkg::ST_FIN;
        end else begin
          cursor_d = cursor_nxt;
          s_raddr  = cursor_nxt;
          ptr_d    = ptr_q + PW'(1);
          if (int'(ptr_q) == SPRITE_SLOTS - 1) begin
            w_status_d = 1'b1;
            state_d    = tsae_pkg::ST_FIN;
          end
        end
      end

      tsae_pkg::ST_DEL_RD: state_d = tsae_pkg::ST_DEL_WR;

      tsae_pkg::ST_DEL_WR: begin
        s_wdata         = s_rdata;
        s_wdata.enabled = 1'b0;
        s_we            = slot_ok;
        state_d         = tsae_pkg::ST_FIN;
      end

      tsae_pkg::ST_TT_RD: begin
        t_raddr = ptr_q[TAW-1:0];
        if (int'(ptr_q) < int'(tiu_q) && int'(ptr_q) < TILE_ENTRIES) begin
          state_d = tsae_pkg::ST_TT_WR;
        end else begin
          ptr_d   = '0;
          state_d = tsae_pkg::ST_ST_RD;
        end
      end

      tsae_pkg::ST_TT_WR: begin
        pos_nxt = tsae_pkg::advance({t_rdata.phase, t_rdata.frame_now}, t_rdata.period,
                                    t_rdata.frames, t_rdata.wraps);
        t_waddr           = ptr_q[TAW-1:0];
        t_wdata           = t_rdata;
        t_wdata.phase     = pos_nxt.phase;
        t_wdata.frame_now = pos_nxt.frame;
        t_we              = t_rdata.stepping;
        ptr_d             = ptr_q + PW'(1);
        state_d           = tsae_pkg::ST_TT_RD;
      end

      tsae_pkg::ST_ST_RD: begin
        s_raddr = ptr_q[SAW-1:0];
        if (int'(ptr_q) < SPRITE_SLOTS) begin
          state_d = tsae_pkg::ST_ST_TRD;
        end else begin
          state_d = tsae_pkg::ST_FIN;
        end
      end

      tsae_pkg::ST_ST_TRD: begin
        sw_d    = s_rdata;
        t_raddr = TAW'(s_rdata.tile);
        state_d = tsae_pkg::ST_ST_WR;
      end

      tsae_pkg::ST_ST_WR: begin
        pos_nxt = tsae_pkg::advance({sw_q.phase, sw_q.frame_now}, t_rdata.period,
                                    t_rdata.frames, t_rdata.wraps);
        s_waddr           = ptr_q[SAW-1:0];
        s_wdata           = sw_q;
        s_wdata.phase     = pos_nxt.phase;
        s_wdata.frame_now = pos_nxt.frame;
        s_we              = sw_q.stepping && stile_ok;
        ptr_d             = ptr_q + PW'(1);
        state_d           = tsae_pkg::ST_ST_RD;
      end

      tsae_pkg::ST_RD_WAIT: begin
        if (kind_q == tsae_pkg::KIND_READ_TILE) begin
          w_frame_d = tile_ok ? t_rdata.frame_now : '0;
        end else begin
          w_frame_d = slot_ok ? s_rdata.frame_now : '0;
        end
        state_d = tsae_pkg::ST_FIN;
      end

      tsae_pkg::ST_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = tsae_pkg::ST_IDLE;
        end
      end

      default: state_d = tsae_pkg::ST_IDLE;
    endcase
  end

  assign rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsae_pkg::ST_CLEAR;
      ptr_q       <= '0;
      cursor_q    <= '0;
      tiu_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cursor_q    <= cursor_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        tiu_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sw_q       <= sw_d;
    w_status_q <= w_status_d;
    w_slot_q   <= w_slot_d;
    w_frame_q  <= w_frame_d;
    if (req_acc) begin
      kind_q <= req_i.kind;
      idx_q  <= req_i.index;
      cnt_q  <= req_i.frame_count;
      loop_q <= req_i.loop_flag;
    end
    if (rsp_load) begin
      rsp_status_q <= w_status_q;
      rsp_slot_q   <= w_slot_q;
      rsp_frame_q  <= w_frame_q;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.slot   = rsp_slot_q;
  assign rsp_o.frame  = rsp_frame_q;

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == tsae_pkg::ST_FIN)
    else $error("result raised outside the finish step");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cursor_q) < SPRITE_SLOTS)
    else $error("allocation cursor out of range");

  a_div_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == tsae_pkg::ST_LOAD_DIV)
    else $error("divider running outside a tile load");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsae_pkg::ST_FIN && rsp_valid_q && !rsp_o.ready)
      |=> state_q == tsae_pkg::ST_FIN)
    else $error("pending result overwritten");

  a_tile_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_we |-> (state_q == tsae_pkg::ST_CLEAR || state_q == tsae_pkg::ST_LOAD_DIV ||
              state_q == tsae_pkg::ST_TT_WR))
    else $error("unexpected tile RAM write");

endmodule
